>>> rtl/widerwake_stream_cipher_top_defines.svh
// Assertion macros shared by the checker of the cipher block.
`ifndef WIDERWAKE_STREAM_CIPHER_TOP_DEFINES_SVH
`define WIDERWAKE_STREAM_CIPHER_TOP_DEFINES_SVH

// Next-cycle implication checked on the rising clock edge outside reset.
`define WW_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

// Same-cycle implication checked on the rising clock edge outside reset.
`define WW_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

>>> rtl/ww_pkg.sv
// Types, constants and helper functions of the WiderWake cipher block.
`default_nettype none
package ww_pkg;

	localparam int unsigned TableDepth = 256;
	localparam int unsigned TableAw    = $clog2(TableDepth);

	localparam logic [1:0] KIND_REKEY  = 2'd0;
	localparam logic [1:0] KIND_RESYNC = 2'd1;
	localparam logic [1:0] KIND_DATA   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [2:0] REG_KEY0   = 3'd0;
	localparam logic [2:0] REG_KEY1   = 3'd1;
	localparam logic [2:0] REG_KEY2   = 3'd2;
	localparam logic [2:0] REG_KEY3   = 3'd3;
	localparam logic [2:0] REG_IV_HI  = 3'd4;
	localparam logic [2:0] REG_IV_LO  = 3'd5;

	localparam logic [7:0]  MIX_OFFSET = 8'd89;
	localparam logic [7:0]  MIX_LAST   = 8'd22;
	localparam logic [7:0]  X_ADDR     = 8'd33;
	localparam logic [7:0]  Z_ADDR     = 8'd59;
	localparam logic [7:0]  INIT_LAST  = 8'd3;
	localparam logic [7:0]  LAST_IDX   = 8'd255;
	localparam logic [31:0] Z_SET      = 32'h01000001;
	localparam logic [31:0] Z_CLR      = 32'hFF7FFFFF;
	localparam logic [31:0] LOW_MASK   = 32'h00FFFFFF;
	localparam logic [3:0]  LAST_STEP  = 4'd8;
	localparam logic [2:0]  LOOK_LAST  = 3'd4;

	typedef struct packed {
		logic [31:0] key0;
		logic [31:0] key1;
		logic [31:0] key2;
		logic [31:0] key3;
		logic [31:0] iv_hi;
		logic [31:0] iv_lo;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LATCH, OP_INIT_W, OP_GEN,
		OP_MIX_RA, OP_MIX_RB, OP_MIX_W,
		OP_XZ_RA, OP_XZ_RB, OP_XZ_C,
		OP_ADD_R, OP_ADD_W,
		OP_SH_R, OP_SH_X, OP_SH_Z, OP_SH_0,
		OP_SW_A, OP_SW_B, OP_SW_C, OP_SW_D, OP_SW_END,
		OP_LOAD, OP_SUM, OP_LOOK, OP_DATA
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [7:0] j;
		logic [2:0] k;
		logic       use_iv;
		logic       ks;
	} cmd_t;

	typedef struct packed {
		logic pos_wrap;
	} sts_t;

	function automatic logic [31:0] magic(input logic [2:0] sel);
		logic [31:0] m;
		case (sel)
			3'd0: m = 32'h726A8F3B;
			3'd1: m = 32'hE69A3B5C;
			3'd2: m = 32'hD3C71FE5;
			3'd3: m = 32'hAB3C73D2;
			3'd4: m = 32'h4D3A8EB3;
			3'd5: m = 32'h0396D6E8;
			3'd6: m = 32'h3D4C2F7A;
			default: m = 32'h9EE27CF3;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

>>> rtl/ww_if.sv
// Valid/ready stream interfaces for the input items and the result bytes.
`default_nettype none
interface ww_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface ww_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	modport source (output valid, output out_byte, input ready);
	modport sink (input valid, input out_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/widerwake_stream_cipher_top.sv
// Top level of the WiderWake 4+1 big-endian stream cipher with its APB register file.
// A data transaction is registered in the output byte; every fourth data byte is followed
// by one cipher step (the adds, then four lookups through the single read port of the
// table RAM), during which no transaction is accepted. A resync blocks the input for nine
// steps after it is accepted. A rekey rebuilds the 256-word table through the same RAM
// sequencer and blocks the input after it is accepted until a register load with a zero IV
// and its nine steps are done. Results wait in a single output register; a new transaction
// is accepted only when that register is empty or is read in the same cycle.
`default_nettype none
module widerwake_stream_cipher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ww_in_if.sink            in_ch,
	ww_out_if.source         out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import ww_pkg::*;

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	logic [2:0] reg_idx;
	logic       in_ready, out_valid;
	logic [7:0] out_byte;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_KEY0:  cfg_q.key0  <= pwdata;
				REG_KEY1:  cfg_q.key1  <= pwdata;
				REG_KEY2:  cfg_q.key2  <= pwdata;
				REG_KEY3:  cfg_q.key3  <= pwdata;
				REG_IV_HI: cfg_q.iv_hi <= pwdata;
				REG_IV_LO: cfg_q.iv_lo <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_KEY0:  prdata = cfg_q.key0;
			REG_KEY1:  prdata = cfg_q.key1;
			REG_KEY2:  prdata = cfg_q.key2;
			REG_KEY3:  prdata = cfg_q.key3;
			REG_IV_HI: prdata = cfg_q.iv_hi;
			REG_IV_LO: prdata = cfg_q.iv_lo;
			default:   prdata = 32'h0;
		endcase
	end

	ww_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_kind(in_ch.kind), .in_ready(in_ready),
		.out_valid_q(out_valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	ww_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg(cfg_q),
		.data_byte(in_ch.data_byte), .sts(sts), .out_byte_q(out_byte)
	);

	assign in_ch.ready     = in_ready;
	assign out_ch.valid    = out_valid;
	assign out_ch.out_byte = out_byte;
endmodule
`default_nettype wire

>>> rtl/ww_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ww_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/ww_dp.sv
// Datapath: table RAM, cipher registers, key schedule arithmetic and output byte.
`default_nettype none
module ww_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ww_pkg::cmd_t  cmd,
	input  wire ww_pkg::cfg_t  cfg,
	input  wire logic [7:0]    data_byte,
	output ww_pkg::sts_t       sts,
	output logic [7:0]         out_byte_q
);
	import ww_pkg::*;

	logic [31:0] lk_q [4];
	logic [31:0] win_q [4];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] sum_q [4];
	logic [23:0] hi_q;
	logic [31:0] n_q [3];
	logic [31:0] x_q, z_q, tmp_q, ks_q;
	logic [1:0]  pos_q;

	logic               we;
	logic [TableAw-1:0] waddr, raddr;
	logic [31:0]        wdata, rdata;
	logic [31:0]        gen_s, gen_v, add_x, look_v, ivh, ivl;
	logic [7:0]         sw_x, ks_byte;

	ww_ram #(.Width(32), .Depth(TableDepth)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign gen_s  = win_q[3] + win_q[0];
	assign gen_v  = {3'b000, gen_s[31:3]} ^ magic(gen_s[2:0]);
	assign add_x  = (x_q & Z_CLR) + z_q;
	assign look_v = {8'h00, hi_q} ^ rdata;
	assign sw_x   = rdata[7:0] ^ x_q[7:0];
	assign ivh    = cmd.use_iv ? cfg.iv_hi : 32'h0;
	assign ivl    = cmd.use_iv ? cfg.iv_lo : 32'h0;
	assign sts.pos_wrap = (pos_q == 2'd3);

	always_comb begin
		case (pos_q)
			2'd0: ks_byte = ks_q[31:24];
			2'd1: ks_byte = ks_q[23:16];
			2'd2: ks_byte = ks_q[15:8];
			default: ks_byte = ks_q[7:0];
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = cmd.j;
		wdata = 32'h0;
		raddr = cmd.j;
		case (cmd.op)
			OP_INIT_W: begin
				we    = 1'b1;
				wdata = lk_q[cmd.j[1:0]];
			end
			OP_GEN: begin
				we    = 1'b1;
				wdata = gen_v;
			end
			OP_MIX_RB: raddr = cmd.j + MIX_OFFSET;
			OP_MIX_W: begin
				we    = 1'b1;
				wdata = tmp_q + rdata;
			end
			OP_XZ_RA: raddr = X_ADDR;
			OP_XZ_RB: raddr = Z_ADDR;
			OP_ADD_W: begin
				we    = 1'b1;
				wdata = (rdata & LOW_MASK) ^ add_x;
			end
			OP_SH_R: raddr = x_q[7:0];
			OP_SH_X: raddr = 8'd0;
			OP_SH_Z: raddr = x_q[7:0];
			OP_SH_0: begin
				we    = 1'b1;
				waddr = 8'd0;
				wdata = rdata;
			end
			OP_SW_B: begin
				we    = 1'b1;
				waddr = x_q[7:0];
				wdata = rdata;
				raddr = cmd.j ^ x_q[7:0];
			end
			OP_SW_C: raddr = sw_x;
			OP_SW_D: begin
				we    = 1'b1;
				wdata = rdata;
			end
			OP_SW_END: begin
				we    = 1'b1;
				waddr = x_q[7:0];
				wdata = z_q;
			end
			OP_LOOK: raddr = sum_q[0][7:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= '0;
			b_q   <= '0;
			c_q   <= '0;
			d_q   <= '0;
			e_q   <= '0;
			ks_q  <= '0;
			pos_q <= '0;
			for (int i = 0; i < 4; i++) begin
				lk_q[i] <= '0;
			end
		end else begin
			case (cmd.op)
				OP_LATCH: begin
					lk_q[0] <= cfg.key0;
					lk_q[1] <= cfg.key1;
					lk_q[2] <= cfg.key2;
					lk_q[3] <= cfg.key3;
				end
				OP_LOAD: begin
					a_q   <= lk_q[0] ^ ivh;
					b_q   <= lk_q[1];
					c_q   <= lk_q[2] ^ ivl;
					d_q   <= lk_q[3];
					e_q   <= ivh;
					pos_q <= '0;
				end
				OP_SUM: begin
					if (cmd.ks) begin
						ks_q <= d_q;
					end
				end
				OP_LOOK: begin
					if (cmd.k == LOOK_LAST) begin
						a_q <= n_q[0];
						b_q <= n_q[1];
						c_q <= n_q[2];
						d_q <= look_v;
						e_q <= a_q;
					end
				end
				OP_DATA: pos_q <= pos_q + 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INIT_W: begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= win_q[3];
				win_q[3] <= lk_q[cmd.j[1:0]];
			end
			OP_GEN: begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= win_q[3];
				win_q[3] <= gen_v;
			end
			OP_MIX_RB: tmp_q <= rdata;
			OP_XZ_RB: x_q <= rdata;
			OP_XZ_C: z_q <= (rdata | Z_SET) & Z_CLR;
			OP_ADD_W: x_q <= add_x;
			OP_SH_X: x_q <= {24'h0, rdata[7:0] ^ x_q[7:0]};
			OP_SH_Z: z_q <= rdata;
			OP_SW_C: x_q <= {24'h0, sw_x};
			OP_SUM: begin
				sum_q[0] <= e_q + d_q;
				sum_q[1] <= b_q + a_q;
				sum_q[2] <= c_q + b_q;
				sum_q[3] <= d_q + c_q;
			end
			OP_LOOK: begin
				sum_q[0] <= sum_q[1];
				sum_q[1] <= sum_q[2];
				sum_q[2] <= sum_q[3];
				hi_q     <= sum_q[0][31:8];
				if (cmd.k != 3'd0) begin
					n_q[0] <= n_q[1];
					n_q[1] <= n_q[2];
					n_q[2] <= look_v;
				end
			end
			OP_DATA: out_byte_q <= data_byte ^ ks_byte;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/ww_ctrl.sv
// Controller: sequences rekey, resync, cipher steps and data transactions.
`default_nettype none
module ww_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic [1:0]   in_kind,
	output logic              in_ready,
	output logic              out_valid_q,
	input  wire logic         out_ready,
	input  wire ww_pkg::sts_t sts,
	output ww_pkg::cmd_t      cmd
);
	import ww_pkg::*;

	typedef enum logic [23:0] {
		ST_IDLE   = 24'h000001, ST_INIT   = 24'h000002, ST_GEN    = 24'h000004,
		ST_MIX_RA = 24'h000008, ST_MIX_RB = 24'h000010, ST_MIX_W  = 24'h000020,
		ST_XZ_RA  = 24'h000040, ST_XZ_RB  = 24'h000080, ST_XZ_C   = 24'h000100,
		ST_ADD_R  = 24'h000200, ST_ADD_W  = 24'h000400, ST_SH_R   = 24'h000800,
		ST_SH_X   = 24'h001000, ST_SH_Z   = 24'h002000, ST_SH_0   = 24'h004000,
		ST_SW_A   = 24'h008000, ST_SW_B   = 24'h010000, ST_SW_C   = 24'h020000,
		ST_SW_D   = 24'h040000, ST_SW_END = 24'h080000, ST_LOAD   = 24'h100000,
		ST_SUM    = 24'h200000, ST_LOOK   = 24'h400000
	} state_t;

	state_t     st_q, st_nxt;
	logic [7:0] j_q, j_nxt;
	logic [2:0] k_q, k_nxt;
	logic [3:0] step_q, step_nxt;
	logic       fire;

	assign fire = in_valid && in_ready;

	always_comb begin
		st_nxt     = st_q;
		j_nxt      = j_q;
		k_nxt      = k_q;
		step_nxt   = step_q;
		in_ready   = 1'b0;
		cmd.op     = OP_NONE;
		cmd.j      = j_q;
		cmd.k      = k_q;
		cmd.use_iv = 1'b0;
		cmd.ks     = (step_q == LAST_STEP);
		case (st_q)
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (fire) begin
					case (in_kind)
						KIND_REKEY: begin
							cmd.op = OP_LATCH;
							j_nxt  = 8'd0;
							st_nxt = ST_INIT;
						end
						KIND_RESYNC: begin
							cmd.op     = OP_LOAD;
							cmd.use_iv = 1'b1;
							step_nxt   = 4'd0;
							st_nxt     = ST_SUM;
						end
						KIND_DATA: begin
							cmd.op = OP_DATA;
							if (sts.pos_wrap) begin
								step_nxt = LAST_STEP;
								st_nxt   = ST_SUM;
							end
						end
						default: ;
					endcase
				end
			end
			ST_INIT: begin
				cmd.op = OP_INIT_W;
				j_nxt  = j_q + 8'd1;
				if (j_q == INIT_LAST) begin
					st_nxt = ST_GEN;
				end
			end
			ST_GEN: begin
				cmd.op = OP_GEN;
				j_nxt  = j_q + 8'd1;
				if (j_q == LAST_IDX) begin
					st_nxt = ST_MIX_RA;
				end
			end
			ST_MIX_RA: begin
				cmd.op = OP_MIX_RA;
				st_nxt = ST_MIX_RB;
			end
			ST_MIX_RB: begin
				cmd.op = OP_MIX_RB;
				st_nxt = ST_MIX_W;
			end
			ST_MIX_W: begin
				cmd.op = OP_MIX_W;
				j_nxt  = j_q + 8'd1;
				if (j_q == MIX_LAST) begin
					j_nxt  = 8'd0;
					st_nxt = ST_XZ_RA;
				end else begin
					st_nxt = ST_MIX_RA;
				end
			end
			ST_XZ_RA: begin
				cmd.op = OP_XZ_RA;
				st_nxt = ST_XZ_RB;
			end
			ST_XZ_RB: begin
				cmd.op = OP_XZ_RB;
				st_nxt = ST_XZ_C;
			end
			ST_XZ_C: begin
				cmd.op = OP_XZ_C;
				st_nxt = ST_ADD_R;
			end
			ST_ADD_R: begin
				cmd.op = OP_ADD_R;
				st_nxt = ST_ADD_W;
			end
			ST_ADD_W: begin
				cmd.op = OP_ADD_W;
				j_nxt  = j_q + 8'd1;
				st_nxt = (j_q == LAST_IDX) ? ST_SH_R : ST_ADD_R;
			end
			ST_SH_R: begin
				cmd.op = OP_SH_R;
				st_nxt = ST_SH_X;
			end
			ST_SH_X: begin
				cmd.op = OP_SH_X;
				st_nxt = ST_SH_Z;
			end
			ST_SH_Z: begin
				cmd.op = OP_SH_Z;
				st_nxt = ST_SH_0;
			end
			ST_SH_0: begin
				cmd.op = OP_SH_0;
				j_nxt  = 8'd1;
				st_nxt = ST_SW_A;
			end
			ST_SW_A: begin
				cmd.op = OP_SW_A;
				st_nxt = ST_SW_B;
			end
			ST_SW_B: begin
				cmd.op = OP_SW_B;
				st_nxt = ST_SW_C;
			end
			ST_SW_C: begin
				cmd.op = OP_SW_C;
				st_nxt = ST_SW_D;
			end
			ST_SW_D: begin
				cmd.op = OP_SW_D;
				j_nxt  = j_q + 8'd1;
				st_nxt = (j_q == LAST_IDX) ? ST_SW_END : ST_SW_A;
			end
			ST_SW_END: begin
				cmd.op = OP_SW_END;
				st_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.op   = OP_LOAD;
				step_nxt = 4'd0;
				st_nxt   = ST_SUM;
			end
			ST_SUM: begin
				cmd.op = OP_SUM;
				k_nxt  = 3'd0;
				st_nxt = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.op = OP_LOOK;
				k_nxt  = k_q + 3'd1;
				if (k_q == LOOK_LAST) begin
					if (step_q == LAST_STEP) begin
						st_nxt = ST_IDLE;
					end else begin
						step_nxt = step_q + 4'd1;
						st_nxt   = ST_SUM;
					end
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			j_q         <= '0;
			k_q         <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q   <= st_nxt;
			j_q    <= j_nxt;
			k_q    <= k_nxt;
			step_q <= step_nxt;
			if (cmd.op == OP_DATA) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/ww_checker.sv
// Port-level checker for the cipher block and its bind to the top level.
`default_nettype none
`include "widerwake_stream_cipher_top_defines.svh"
module ww_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [1:0] in_kind,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte
);
	import ww_pkg::*;

	`WW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`WW_ASSERT_NEXT(a_rekey_busy, in_valid && in_ready && in_kind == KIND_REKEY, !in_ready, "rekey did not block")
	`WW_ASSERT_NEXT(a_resync_busy, in_valid && in_ready && in_kind == KIND_RESYNC, !in_ready, "resync did not block")
	`WW_ASSERT_NEXT(a_data_result, in_valid && in_ready && in_kind == KIND_DATA, out_valid, "data transaction gave no result")
	`WW_ASSERT_NOW(a_out_stable, out_valid && $past(out_valid && !out_ready), $stable(out_byte), "stalled result changed")
endmodule

bind widerwake_stream_cipher_top ww_checker u_ww_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_byte(out_ch.out_byte)
);
`default_nettype wire

>>> dv/ww_stream_checker.sv
// Checker for the cipher block: predicts output bytes from accepted input transactions.
`default_nettype none
module ww_stream_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  in_kind,
	input  wire logic [7:0]  in_data,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [7:0]  out_byte,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_addr,
	input  wire logic [31:0] cfg_data,
	output int               fail_count,
	output int               pending_count
);
	import ww_pkg::*;

	logic [31:0] sbox [256];
	logic [31:0] ra, rb, rc, rd, re;
	logic [31:0] ks_word;
	logic [1:0]  ks_pos;
	logic [31:0] key_reg [4];
	logic [31:0] key_held [4];
	logic [31:0] iv_hi_reg, iv_lo_reg;
	logic [7:0]  cipher_bytes [$];

	function automatic logic [31:0] mix_f(input logic [31:0] x);
		return (x >> 8) ^ sbox[x[7:0]];
	endfunction

	task automatic cipher_step();
		logic [31:0] na;
		na = re + rd;
		rd = rd + rc;
		rc = rc + rb;
		rb = rb + ra;
		na = mix_f(na);
		rb = mix_f(rb);
		rc = mix_f(rc);
		rd = mix_f(rd);
		re = ra;
		ra = na;
	endtask

	task automatic load_regs(input logic [31:0] ivh, input logic [31:0] ivl);
		ra = key_held[0] ^ ivh;
		rb = key_held[1];
		rc = key_held[2] ^ ivl;
		rd = key_held[3];
		re = ivh;
		for (int i = 0; i < 8; i++) cipher_step();
		ks_word = rd;
		cipher_step();
		ks_pos = 2'd0;
	endtask

	task automatic build_table();
		logic [31:0] x, z, s;
		for (int j = 0; j < 4; j++) begin
			key_held[j] = key_reg[j];
			sbox[j] = key_reg[j];
		end
		for (int j = 4; j < 256; j++) begin
			s = sbox[j-1] + sbox[j-4];
			sbox[j] = (s >> 3) ^ magic(s[2:0]);
		end
		for (int j = 0; j < 23; j++) sbox[j] = sbox[j] + sbox[j+89];
		x = sbox[33];
		z = (sbox[59] | 32'h01000001) & 32'hFF7FFFFF;
		for (int j = 0; j < 256; j++) begin
			x = (x & 32'hFF7FFFFF) + z;
			sbox[j] = (sbox[j] & 32'h00FFFFFF) ^ x;
		end
		x = (sbox[x[7:0]] ^ x) & 32'hFF;
		z = sbox[0];
		sbox[0] = sbox[x[7:0]];
		for (int j = 1; j < 256; j++) begin
			sbox[x[7:0]] = sbox[j];
			x = (sbox[8'(j) ^ x[7:0]] ^ x) & 32'hFF;
			sbox[j] = sbox[x[7:0]];
		end
		sbox[x[7:0]] = z;
		load_regs(32'd0, 32'd0);
	endtask

	task automatic predict_data(input logic [7:0] d);
		logic [7:0] k;
		k = ks_word[8*(3-ks_pos) +: 8];
		cipher_bytes.push_back(d ^ k);
		ks_pos = ks_pos + 2'd1;
		if (ks_pos == 0) begin
			ks_word = rd;
			cipher_step();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ra = 0; rb = 0; rc = 0; rd = 0; re = 0;
			ks_word = 0; ks_pos = 2'd0;
			iv_hi_reg = 0; iv_lo_reg = 0;
			for (int i = 0; i < 4; i++) begin
				key_reg[i] = 0;
				key_held[i] = 0;
			end
			for (int i = 0; i < 256; i++) sbox[i] = 0;
			cipher_bytes.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (cipher_bytes.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected output transaction: out_byte=%02h", out_byte);
				end else begin
					if (cipher_bytes[0] !== out_byte) begin
						fail_count++;
						if (fail_count <= 10)
							$display("out_byte mismatch: expected %02h actual %02h",
								cipher_bytes[0], out_byte);
					end
					void'(cipher_bytes.pop_front());
				end
			end
			if (cfg_we) begin
				case (cfg_addr[4:2])
					REG_KEY0: key_reg[0] = cfg_data;
					REG_KEY1: key_reg[1] = cfg_data;
					REG_KEY2: key_reg[2] = cfg_data;
					REG_KEY3: key_reg[3] = cfg_data;
					REG_IV_HI: iv_hi_reg = cfg_data;
					REG_IV_LO: iv_lo_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (in_kind)
					KIND_REKEY: build_table();
					KIND_RESYNC: load_regs(iv_hi_reg, iv_lo_reg);
					KIND_DATA: predict_data(in_data);
					default: ;
				endcase
			end
		end
		pending_count = cipher_bytes.size();
	end

	final begin
		if (cipher_bytes.size() != 0) ;
	end
endmodule
`default_nettype wire

>>> dv/tb_widerwake_stream_cipher_top.sv
// Testbench top: drives stimulus and register writes into the cipher block and reports.
`default_nettype none
module tb_widerwake_stream_cipher_top;
	import ww_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [4:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count, pending_count;
	int          src_idle_pct = 33, snk_idle_pct = 56;
	int          hold_cycles = 0;
	bit          stim_done = 0;

	ww_in_if  in_ch ();
	ww_out_if out_ch ();

	widerwake_stream_cipher_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ww_stream_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
		.in_data(in_ch.data_byte),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_byte(out_ch.out_byte),
		.cfg_we(psel && penable && pwrite && pready), .cfg_addr(paddr), .cfg_data(pwdata),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.kind = KIND_DATA;
		in_ch.data_byte = 0;
		out_ch.ready = 0;
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ch.ready <= 0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [7:0] d);
		if ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.kind <= kind;
		in_ch.data_byte <= d;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (2200) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic set_key(input logic [31:0] k0, k1, k2, k3, ivh, ivl);
		reg_write(REG_KEY0, k0);
		reg_write(REG_KEY1, k1);
		reg_write(REG_KEY2, k2);
		reg_write(REG_KEY3, k3);
		reg_write(REG_IV_HI, ivh);
		reg_write(REG_IV_LO, ivl);
	endtask

	task automatic random_phase(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 2) send_item(KIND_RESYNC, 8'($urandom));
			else if (r < 4) send_item(KIND_UNUSED, 8'($urandom));
			else send_item(KIND_DATA, 8'($urandom));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		set_key(0, 0, 0, 0, 0, 0);
		send_item(KIND_REKEY, 8'h00);
		send_item(KIND_DATA, 8'h00);
		send_item(KIND_DATA, 8'hFF);
		send_item(KIND_DATA, 8'h5A);
		send_item(KIND_DATA, 8'hA5);
		send_item(KIND_UNUSED, 8'hFF);
		send_item(KIND_DATA, 8'h01);
		send_item(KIND_RESYNC, 8'h00);
		send_item(KIND_DATA, 8'h80);
		wait_drained();
		set_key('1, '1, '1, '1, '1, '1);
		send_item(KIND_RESYNC, 8'h00);
		for (int i = 0; i < 6; i++) send_item(KIND_DATA, 8'($urandom));
		send_item(KIND_REKEY, 8'h00);
		for (int i = 0; i < 6; i++) send_item(KIND_DATA, 8'($urandom));
		send_item(KIND_RESYNC, 8'h00);
		for (int i = 0; i < 4; i++) send_item(KIND_DATA, 8'($urandom));
		for (int ph = 0; ph < 3; ph++) begin
			wait_drained();
			src_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 56 : 0;
			snk_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 33 : 0;
			set_key($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			send_item(KIND_REKEY, 8'h00);
			random_phase(200);
			hold_cycles = 300;
			random_phase(30);
			wait_drained();
			reg_write(REG_IV_HI, $urandom);
			reg_write(REG_IV_LO, $urandom);
			send_item(KIND_RESYNC, 8'h00);
			random_phase(230);
		end
		wait_drained();
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("tb_widerwake_stream_cipher_top: done, clean");
		end else begin
			$display("tb_widerwake_stream_cipher_top: done, errors");
		end
		$finish;
	end

	initial begin
		#30000000;
		$display("tb_widerwake_stream_cipher_top: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

>>> widerwake_stream_cipher_top.f
+incdir+rtl
rtl/ww_pkg.sv
rtl/ww_if.sv
rtl/ww_ram.sv
rtl/ww_dp.sv
rtl/ww_ctrl.sv
rtl/widerwake_stream_cipher_top.sv
rtl/ww_checker.sv
dv/ww_stream_checker.sv
dv/tb_widerwake_stream_cipher_top.sv
